// File: rtl/wsts_pkg.sv
// Shared types, widths and codes for the weighted-score tick scheduler.
`timescale 1ns / 1ps
package wsts_pkg;

   // Field widths
   localparam int PID_W     = 16;
   localparam int ARR_W     = 16;
   localparam int REM_W     = 16;
   localparam int PRIO_W    = 8;
   localparam int FUNC_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int NOW_W     = 23;
   localparam int WEIGHT_W  = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Score: weight (s16) times a 17- or 9-bit signed operand, three terms summed
   localparam int PROD_W    = WEIGHT_W + REM_W + 1;
   localparam int PROD_P_W  = WEIGHT_W + PRIO_W + 1;
   localparam int SCORE_W   = PROD_W + 2;

   localparam logic [NOW_W-1:0] NOW_MAX = {NOW_W{1'b1}};

   localparam int ENTRIES_DEF = 64;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // CSR register indexes
   localparam logic [1:0] REG_W_REMAIN = 2'd0;
   localparam logic [1:0] REG_W_ARRIVE = 2'd1;
   localparam logic [1:0] REG_W_PRIO   = 2'd2;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_ADDED = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_SLICE = 2'd2,
      STAT_DONE  = 2'd3
   } status_type;

   // One process table entry
   typedef struct packed {
      logic [PID_W-1:0]  pid;
      logic [ARR_W-1:0]  arrival;
      logic [REM_W-1:0]  remaining;
      logic [PRIO_W-1:0] prio;
   } entry_type;

endpackage

// File: rtl/wsts_score_unit.sv
// Two-stage scoring pipeline: weighted products, then their sum, with entry sideband.
`timescale 1ns / 1ps
module wsts_score_unit #(
   parameter int ENTRIES = wsts_pkg::ENTRIES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [wsts_pkg::WEIGHT_W-1:0]   w_remain,
   input  logic signed [wsts_pkg::WEIGHT_W-1:0]   w_arrive,
   input  logic signed [wsts_pkg::WEIGHT_W-1:0]   w_prio,
   input  logic                                   in_vld,
   input  wsts_pkg::entry_type                    in_ent,
   input  logic [$clog2(ENTRIES)-1:0]             in_slot,
   output logic                                   out_vld,
   output wsts_pkg::entry_type                    out_ent,
   output logic [$clog2(ENTRIES)-1:0]             out_slot,
   output logic signed [wsts_pkg::SCORE_W-1:0]    out_score
);
   import wsts_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   logic                       a_vld_ff;
   entry_type                  a_ent_ff;
   logic [IDX_W-1:0]           a_slot_ff;
   logic signed [PROD_W-1:0]   a_pr_ff;
   logic signed [PROD_W-1:0]   a_pa_ff;
   logic signed [PROD_P_W-1:0] a_pp_ff;
   logic signed [PROD_W-1:0]   a_pr_in;
   logic signed [PROD_W-1:0]   a_pa_in;
   logic signed [PROD_P_W-1:0] a_pp_in;

   logic                       b_vld_ff;
   entry_type                  b_ent_ff;
   logic [IDX_W-1:0]           b_slot_ff;
   logic signed [SCORE_W-1:0]  b_score_ff;
   logic signed [SCORE_W-1:0]  b_score_in;

   // Stage A: three weight products, operands zero-extended to signed
   assign a_pr_in = PROD_W'(w_remain) * PROD_W'($signed({1'b0, in_ent.remaining}));
   assign a_pa_in = PROD_W'(w_arrive) * PROD_W'($signed({1'b0, in_ent.arrival}));
   assign a_pp_in = PROD_P_W'(w_prio) * PROD_P_W'($signed({1'b0, in_ent.prio}));

   // Stage B: exact sum of the products
   assign b_score_in = SCORE_W'(a_pr_ff) + SCORE_W'(a_pa_ff) + SCORE_W'(a_pp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_vld;
         b_vld_ff <= a_vld_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ent_ff   <= in_ent;
      a_slot_ff  <= in_slot;
      a_pr_ff    <= a_pr_in;
      a_pa_ff    <= a_pa_in;
      a_pp_ff    <= a_pp_in;
      b_ent_ff   <= a_ent_ff;
      b_slot_ff  <= a_slot_ff;
      b_score_ff <= b_score_in;
   end

   assign out_vld   = b_vld_ff;
   assign out_ent   = b_ent_ff;
   assign out_slot  = b_slot_ff;
   assign out_score = b_score_ff;

endmodule

// File: rtl/weighted_score_tick_scheduler_unit.sv
// Top level of the weighted-score tick scheduler: table, sequencer, CSRs, response register.
//
//  Channel | Direction | Handshake          | Beat contents
//  req     | in        | req_valid/req_stall | func, proc_id, arrive_at, burst, prio
//  rsp     | out       | rsp_valid/rsp_stall | status, run_id, slice_start
//  csr     | in/out    | APB psel/penable    | three signed Q8.8 weights
//
// Add and clear pass from accept through the reply state to the response register. A tick
// scans the filled table: one table read per cycle feeds the scoring pipeline (3 deep),
// which then drains. A tick that must jump time to the earliest arrival scans twice.
// Reset (synchronous) empties the table via the fill count; no clearing pass.
// req_stall is high while an item is in work; a held response does not block acceptance,
// but the next result waits until the response register is free.
`timescale 1ns / 1ps
module weighted_score_tick_scheduler_unit #(
   parameter int ENTRIES = wsts_pkg::ENTRIES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [wsts_pkg::FUNC_W-1:0]        req_func,
   input  logic [wsts_pkg::PID_W-1:0]         req_proc_id,
   input  logic [wsts_pkg::ARR_W-1:0]         req_arrive_at,
   input  logic [wsts_pkg::REM_W-1:0]         req_burst,
   input  logic [wsts_pkg::PRIO_W-1:0]        req_prio,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [wsts_pkg::STATUS_W-1:0]      rsp_status,
   output logic [wsts_pkg::PID_W-1:0]         rsp_run_id,
   output logic [wsts_pkg::NOW_W-1:0]         rsp_slice_start,
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [wsts_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [wsts_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [wsts_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import wsts_pkg::*;

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int FILL_W = $clog2(ENTRIES + 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_REPLY  = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic [NOW_W-1:0]           now_ff, now_in;
   logic [IDX_W-1:0]           iss_ff, iss_in;
   logic [1:0]                 drain_ff, drain_in;
   logic                       pass2_ff, pass2_in;
   logic                       pend_ff, pend_in;
   logic [ARR_W-1:0]           early_ff, early_in;
   logic                       best_vld_ff, best_vld_in;
   entry_type                  best_ent_ff, best_ent_in;
   logic [IDX_W-1:0]           best_slot_ff, best_slot_in;
   logic signed [SCORE_W-1:0]  best_score_ff, best_score_in;
   status_type                 res_status_ff, res_status_in;
   logic [PID_W-1:0]           res_id_ff, res_id_in;
   logic [NOW_W-1:0]           res_start_ff, res_start_in;
   logic                       rsp_load;
   logic                       rsp_valid_ff;
   status_type                 rsp_status_ff;
   logic [PID_W-1:0]           rsp_id_ff;
   logic [NOW_W-1:0]           rsp_start_ff;

   logic signed [WEIGHT_W-1:0] w_remain_ff;
   logic signed [WEIGHT_W-1:0] w_arrive_ff;
   logic signed [WEIGHT_W-1:0] w_prio_ff;

   // process table memory
   entry_type                  mem [ENTRIES];
   entry_type                  mem_q_ff;
   logic                       mem_we;
   logic [IDX_W-1:0]           mem_wa;
   entry_type                  mem_wd;
   logic                       s1_vld_ff;
   logic [IDX_W-1:0]           s1_slot_ff;

   logic                       req_accept;
   logic                       table_full;
   logic                       iss_last;
   logic                       s1_pend;
   logic                       s1_elig;
   entry_type                  req_ent;

   logic                       su_vld;
   entry_type                  su_ent;
   logic [IDX_W-1:0]           su_slot;
   logic signed [SCORE_W-1:0]  su_score;
   logic                       su_better;
   logic                       csr_wr;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign table_full = (fill_ff == FILL_W'(ENTRIES));
   assign iss_last   = ((FILL_W'(iss_ff) + FILL_W'(1)) == fill_ff);

   assign req_ent.pid       = req_proc_id;
   assign req_ent.arrival   = req_arrive_at;
   assign req_ent.remaining = req_burst;
   assign req_ent.prio      = req_prio;

   // Scan front: entry read last cycle, pending and eligibility
   assign s1_pend = s1_vld_ff && (mem_q_ff.remaining != '0);
   assign s1_elig = s1_pend && ({{(NOW_W-ARR_W){1'b0}}, mem_q_ff.arrival} <= now_ff);

   wsts_score_unit #(
      .ENTRIES (ENTRIES)
   ) u_score (
      .clock     (clock),
      .reset     (reset),
      .w_remain  (w_remain_ff),
      .w_arrive  (w_arrive_ff),
      .w_prio    (w_prio_ff),
      .in_vld    (s1_elig),
      .in_ent    (mem_q_ff),
      .in_slot   (s1_slot_ff),
      .out_vld   (su_vld),
      .out_ent   (su_ent),
      .out_slot  (su_slot),
      .out_score (su_score)
   );

   // Higher score wins; ties go to earlier arrival, then lower pid, then lower slot
   assign su_better = !best_vld_ff || (su_score > best_score_ff) ||
                      ((su_score == best_score_ff) &&
                       ((su_ent.arrival < best_ent_ff.arrival) ||
                        ((su_ent.arrival == best_ent_ff.arrival) &&
                         (su_ent.pid < best_ent_ff.pid))));

   // Sequencer and accumulators
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      now_in        = now_ff;
      iss_in        = iss_ff;
      drain_in      = drain_ff;
      pass2_in      = pass2_ff;
      pend_in       = pend_ff;
      early_in      = early_ff;
      best_vld_in   = best_vld_ff;
      best_ent_in   = best_ent_ff;
      best_slot_in  = best_slot_ff;
      best_score_in = best_score_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_start_in  = res_start_ff;
      mem_we        = 1'b0;
      mem_wa        = fill_ff[IDX_W-1:0];
      mem_wd        = req_ent;
      rsp_load      = 1'b0;

      // pending work and earliest arrival
      if (s1_pend) begin
         pend_in = 1'b1;
         if (!pend_ff || (mem_q_ff.arrival < early_ff)) begin
            early_in = mem_q_ff.arrival;
         end
      end

      // best candidate from the scoring pipeline
      if (su_vld && su_better) begin
         best_vld_in   = 1'b1;
         best_ent_in   = su_ent;
         best_slot_in  = su_slot;
         best_score_in = su_score;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_func)
                  FUNC_ADD: begin
                     res_id_in    = '0;
                     res_start_in = '0;
                     if (table_full) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        mem_we        = 1'b1;
                        fill_in       = fill_ff + FILL_W'(1);
                        res_status_in = STAT_ADDED;
                     end
                     state_in = ST_REPLY;
                  end
                  FUNC_TICK: begin
                     pend_in     = 1'b0;
                     best_vld_in = 1'b0;
                     pass2_in    = 1'b0;
                     iss_in      = '0;
                     state_in    = (fill_ff == '0) ? ST_DECIDE : ST_SCAN;
                  end
                  FUNC_CLEAR: begin
                     fill_in       = '0;
                     now_in        = '0;
                     res_status_in = STAT_ADDED;
                     res_id_in     = '0;
                     res_start_in  = '0;
                     state_in      = ST_REPLY;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (iss_last) begin
               drain_in = 2'd0;
               state_in = ST_DRAIN;
            end else begin
               iss_in = iss_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (drain_ff == 2'd2) begin
               state_in = ST_DECIDE;
            end else begin
               drain_in = drain_ff + 2'd1;
            end
         end
         ST_DECIDE: begin
            if (pend_ff && best_vld_ff) begin
               // run one slice and charge the winner
               res_status_in       = STAT_SLICE;
               res_id_in           = best_ent_ff.pid;
               res_start_in        = now_ff;
               mem_we              = 1'b1;
               mem_wa              = best_slot_ff;
               mem_wd              = best_ent_ff;
               mem_wd.remaining    = best_ent_ff.remaining - REM_W'(1);
               now_in              = (now_ff == NOW_MAX) ? now_ff : now_ff + NOW_W'(1);
               state_in            = ST_REPLY;
            end else if (pend_ff && !pass2_ff) begin
               // nothing ready yet: jump to the earliest arrival and rescan
               now_in      = {{(NOW_W-ARR_W){1'b0}}, early_ff};
               pass2_in    = 1'b1;
               pend_in     = 1'b0;
               best_vld_in = 1'b0;
               iss_in      = '0;
               state_in    = ST_SCAN;
            end else begin
               res_status_in = STAT_DONE;
               res_id_in     = '0;
               res_start_in  = now_ff;
               state_in      = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         now_ff      <= '0;
         pass2_ff    <= 1'b0;
         pend_ff     <= 1'b0;
         best_vld_ff <= 1'b0;
         s1_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         now_ff      <= now_in;
         pass2_ff    <= pass2_in;
         pend_ff     <= pend_in;
         best_vld_ff <= best_vld_in;
         s1_vld_ff   <= (state_ff == ST_SCAN);
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      iss_ff        <= iss_in;
      drain_ff      <= drain_in;
      early_ff      <= early_in;
      best_ent_ff   <= best_ent_in;
      best_slot_ff  <= best_slot_in;
      best_score_ff <= best_score_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_start_ff  <= res_start_in;
      s1_slot_ff    <= iss_ff;
   end

   // Process table: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem[iss_ff];
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= res_id_ff;
         rsp_start_ff  <= res_start_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_run_id      = rsp_id_ff;
   assign rsp_slice_start = rsp_start_ff;

   // CSR weights
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_remain_ff <= '0;
         w_arrive_ff <= '0;
         w_prio_ff   <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_W_REMAIN: w_remain_ff <= csr_pwdata[WEIGHT_W-1:0];
            REG_W_ARRIVE: w_arrive_ff <= csr_pwdata[WEIGHT_W-1:0];
            REG_W_PRIO:   w_prio_ff   <= csr_pwdata[WEIGHT_W-1:0];
            default: begin
               w_prio_ff <= w_prio_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_W_REMAIN: csr_prdata = {{(CSR_DATA_W-WEIGHT_W){1'b0}}, w_remain_ff};
         REG_W_ARRIVE: csr_prdata = {{(CSR_DATA_W-WEIGHT_W){1'b0}}, w_arrive_ff};
         REG_W_PRIO:   csr_prdata = {{(CSR_DATA_W-WEIGHT_W){1'b0}}, w_prio_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(ENTRIES))
      else $error("fill count beyond table depth");

   a_best_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && best_vld_ff |-> (FILL_W'(best_slot_ff) < fill_ff))
      else $error("chosen slot outside filled table");

   a_best_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && best_vld_ff |-> (best_ent_ff.remaining != '0))
      else $error("chosen entry has no remaining time");

   a_now_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(req_accept && (req_func == FUNC_CLEAR)) |=> (now_ff >= $past(now_ff)))
      else $error("time counter went backward without a clear");

endmodule
